// ===== rtl/ialu_pkg.sv =====
// ialu_pkg: opcode codes and controller/datapath command and status types
// for the 128-bit integer ALU; no dependencies
package ialu_pkg;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_AND = 4'd4,
        OP_OR  = 4'd5,
        OP_XOR = 4'd6,
        OP_NOT = 4'd7,
        OP_SHL = 4'd8,
        OP_SAR = 4'd9,
        OP_ROL = 4'd10,
        OP_ROR = 4'd11,
        OP_GT  = 4'd12
    } opcode_t;

    localparam int OPCODE_BITS = 4;
    localparam int HALF_BITS   = 64;
    localparam int SHIFT_BITS  = 7;
    localparam int IN_BITS     = 264;
    localparam int OUT_BITS    = 128;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic iterative;
    } dp_status_t;

endpackage

// ===== rtl/ialu_ctrl.sv =====
// ialu_ctrl: sequencing state machine, iteration counter and output valid
// depends on ialu_pkg
module ialu_ctrl #(
    parameter int WORD_BITS = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  ialu_pkg::dp_status_t  status,
    output ialu_pkg::dp_cmd_t     cmd
);
    import ialu_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               valid_reg, valid_next;
    logic               out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !m_tready;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    cnt_next = CNT_W'(WORD_BITS);
                    state_next = status.iterative ? ST_RUN : ST_FINISH;
                end
            end
            ST_RUN: begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== rtl/ialu_dp.sv =====
// ialu_dp: operand registers, shift-add multiplier, restoring divider,
// combinational logic/shift unit and result register; depends on ialu_pkg
module ialu_dp #(
    parameter int WORD_BITS = 128
) (
    input  logic                                aclk,
    input  logic [ialu_pkg::OPCODE_BITS-1:0]    in_opcode,
    input  logic [2*ialu_pkg::HALF_BITS-1:0]    in_first,
    input  logic [2*ialu_pkg::HALF_BITS-1:0]    in_second,
    input  logic [ialu_pkg::SHIFT_BITS-1:0]     in_shift,
    input  ialu_pkg::dp_cmd_t                   cmd,
    output ialu_pkg::dp_status_t                status,
    output logic [ialu_pkg::OUT_BITS-1:0]       result,
    output logic                                divide_by_zero
);
    import ialu_pkg::*;

    localparam int W = WORD_BITS;

    logic [OPCODE_BITS-1:0] op_reg;
    logic [W-1:0]           a_reg, b_reg;
    logic [SHIFT_BITS-1:0]  sh_reg;
    logic [W-1:0]           acc_reg, acc_next;
    logic [W-1:0]           x_reg, x_next;
    logic [W-1:0]           y_reg, y_next;
    logic                   neg_reg, dz_reg;
    logic [OUT_BITS-1:0]    res_reg, res_next;
    logic                   dzo_reg;

    logic [W-1:0]           in_a, in_b, abs_a, abs_b;
    logic                   in_dz;
    logic [W-1:0]           trial;
    logic                   fits;
    logic [W-1:0]           val;

    assign in_a  = in_first[W-1:0];
    assign in_b  = in_second[W-1:0];
    assign in_dz = (in_b == '0);
    assign abs_a = in_a[W-1] ? (~in_a + 1'b1) : in_a;
    assign abs_b = in_b[W-1] ? (~in_b + 1'b1) : in_b;

    assign status.iterative = (in_opcode == OP_MUL) || ((in_opcode == OP_DIV) && !in_dz);

    assign trial = {acc_reg[W-2:0], x_reg[W-1]};
    assign fits  = (trial >= y_reg);

    always_comb begin
        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        if (cmd.load) begin
            acc_next = '0;
            if (in_opcode == OP_DIV) begin
                x_next = abs_a;
                y_next = abs_b;
            end else begin
                x_next = in_a;
                y_next = in_b;
            end
        end else if (cmd.step) begin
            if (op_reg == OP_DIV) begin
                acc_next = fits ? (trial - y_reg) : trial;
                x_next   = {x_reg[W-2:0], fits};
            end else begin
                acc_next = y_reg[0] ? (acc_reg + x_reg) : acc_reg;
                x_next   = {x_reg[W-2:0], 1'b0};
                y_next   = {1'b0, y_reg[W-1:1]};
            end
        end
    end

    always_comb begin
        val = '0;
        case (op_reg)
            OP_ADD: val = a_reg + b_reg;
            OP_SUB: val = a_reg - b_reg;
            OP_MUL: val = acc_reg;
            OP_DIV: val = dz_reg ? '0 : (neg_reg ? (~x_reg + 1'b1) : x_reg);
            OP_AND: val = a_reg & b_reg;
            OP_OR:  val = a_reg | b_reg;
            OP_XOR: val = a_reg ^ b_reg;
            OP_NOT: val = ~a_reg;
            OP_SHL: val = a_reg << sh_reg;
            OP_SAR: val = W'($signed(a_reg) >>> sh_reg);
            OP_ROL: val = {a_reg[W-2:0], a_reg[W-1]};
            OP_ROR: val = {a_reg[0], a_reg[W-1:1]};
            default: val = '0;
        endcase
        if (op_reg == OP_GT) begin
            res_next = OUT_BITS'($signed(a_reg) > $signed(b_reg));
        end else begin
            res_next = OUT_BITS'($signed(val));
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        if (cmd.load) begin
            op_reg  <= in_opcode;
            a_reg   <= in_a;
            b_reg   <= in_b;
            sh_reg  <= in_shift;
            neg_reg <= in_a[W-1] ^ in_b[W-1];
            dz_reg  <= in_dz;
        end
        if (cmd.finish) begin
            res_reg <= res_next;
            dzo_reg <= (op_reg == OP_DIV) && dz_reg;
        end
    end

    assign result         = res_reg;
    assign divide_by_zero = dzo_reg;

endmodule

// ===== rtl/int128_alu.sv =====
// int128_alu: top level of the signed integer ALU, joining controller and datapath
// depends on ialu_pkg, ialu_ctrl and ialu_dp
//
// One beat in, one beat out, and no new beat is taken while one is in flight.
// Multiply and nonzero divide pass through the run state, where the
// one-bit-per-cycle shift-add / restoring-divide loop works, then the finish state;
// every other opcode goes from accept straight to the finish state, which loads
// the result register. A stalled output holds the finished result back,
// and a new beat is taken once the previous result has moved to the output register.
module int128_alu #(
    parameter int WORD_BITS = 128
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // first_high, first_low, second_high, second_low, shift_amount, zero pad
    input  logic [263:0]  s_tdata,
    // opcode
    input  logic [3:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // result_high, result_low
    output logic [127:0]  m_tdata,
    // divide_by_zero
    output logic [0:0]    m_tuser
);
    import ialu_pkg::*;

    dp_cmd_t                cmd;
    dp_status_t             status;
    logic [OUT_BITS-1:0]    result;
    logic                   dz;

    ialu_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ialu_dp #(.WORD_BITS(WORD_BITS)) u_dp (
        .aclk           (aclk),
        .in_opcode      (s_tuser),
        .in_first       ({s_tdata[63:0], s_tdata[127:64]}),
        .in_second      ({s_tdata[191:128], s_tdata[255:192]}),
        .in_shift       (s_tdata[262:256]),
        .cmd            (cmd),
        .status         (status),
        .result         (result),
        .divide_by_zero (dz)
    );

    assign m_tdata = {result[63:0], result[127:64]};
    assign m_tuser = dz;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("beat accepted while busy");
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("divide by zero with nonzero result");
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("not idle after reset");
`endif

endmodule
